@@ hdl/gcs_pkg.sv @@
package gcs_pkg;

    // Drive command words (low byte of the device command word)
    localparam logic [7:0] CMD_NEUTRAL = 8'h80;
    localparam logic [7:0] CMD_OPEN    = 8'h81;
    localparam logic [7:0] CMD_CLOSE   = 8'h82;
    localparam logic [7:0] CMD_CLEAR   = 8'h83;

    // Pulse lengths in bus ticks
    localparam logic [15:0] CLEAR_TICKS         = 16'd20;
    localparam logic [15:0] NEUTRAL_PULSE_TICKS = 16'd4;
    localparam logic [15:0] MOVE_PULSE_TICKS    = 16'd20;
    localparam logic [15:0] NEUTRALIZE_TICKS    = 16'd20;

    // Request commands
    localparam logic [2:0] RQ_STATUS = 3'd0;
    localparam logic [2:0] RQ_CLEAR  = 3'd1;
    localparam logic [2:0] RQ_OPEN   = 3'd2;
    localparam logic [2:0] RQ_CLOSE  = 3'd3;
    localparam logic [2:0] RQ_MOVE   = 3'd4;

    // Device claw status codes
    localparam logic [15:0] CS_FAULT   = 16'd10;
    localparam logic [15:0] CS_READY_A = 16'd3;
    localparam logic [15:0] CS_READY_B = 16'd5;
    localparam logic [15:0] CS_READY_C = 16'd7;
    localparam logic [15:0] CS_READY_D = 16'd8;
    localparam logic [15:0] CS_TERM_E  = 16'd9;

    // Run outcomes
    localparam logic [3:0] OC_NONE         = 4'd0;
    localparam logic [3:0] OC_STATUS       = 4'd1;
    localparam logic [3:0] OC_CLEARED      = 4'd2;
    localparam logic [3:0] OC_REACHED      = 4'd3;
    localparam logic [3:0] OC_TERMINAL     = 4'd4;
    localparam logic [3:0] OC_ALREADY      = 4'd5;
    localparam logic [3:0] OC_CLEAR_FAIL   = 4'd6;
    localparam logic [3:0] OC_READY_FAIL   = 4'd7;
    localparam logic [3:0] OC_RANGE        = 4'd8;
    localparam logic [3:0] OC_UNKNOWN      = 4'd9;
    localparam logic [3:0] OC_MOVE_FAIL    = 4'd10;

    // Configuration register indexes
    localparam logic [2:0] REG_READY_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_MOVE_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_POS_TOL       = 3'd2;
    localparam logic [2:0] REG_OPEN_TARGET   = 3'd3;
    localparam logic [2:0] REG_CLOSE_TARGET  = 3'd4;
    localparam logic [2:0] REG_MIN_WIDTH     = 3'd5;
    localparam logic [2:0] REG_MAX_WIDTH     = 3'd6;

    // Reset values of the configuration and drive width registers
    localparam logic [15:0] RST_READY_TIMEOUT = 16'd4000;
    localparam logic [15:0] RST_MOVE_TIMEOUT  = 16'd6000;
    localparam logic [15:0] RST_POS_TOL       = 16'd3;
    localparam logic [15:0] RST_OPEN_TARGET   = 16'd1800;
    localparam logic [15:0] RST_CLOSE_TARGET  = 16'd1000;
    localparam logic [15:0] RST_MIN_WIDTH     = 16'd1000;
    localparam logic [15:0] RST_MAX_WIDTH     = 16'd1800;

    typedef enum logic [8:0] {
        PH_IDLE        = 9'b000000001,
        PH_CLEAR_PULSE = 9'b000000010,
        PH_FAULT_WAIT  = 9'b000000100,
        PH_READY_WAIT  = 9'b000001000,
        PH_PRE_OPEN    = 9'b000010000,
        PH_PRE_CLOSE   = 9'b000100000,
        PH_MOVE_PULSE  = 9'b001000000,
        PH_MOVE_WAIT   = 9'b010000000,
        PH_NEUTRALIZE  = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [15:0] ready_timeout;
        logic [15:0] move_timeout;
        logic [15:0] position_tolerance;
        logic [15:0] open_target;
        logic [15:0] close_target;
        logic [15:0] min_width;
        logic [15:0] max_width;
    } cfg_t;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  request_cmd;
        logic [15:0] request_width;
        logic [15:0] jaw_state;
        logic [15:0] jaw_fault;
        logic [15:0] axis_fault;
        logic [15:0] finger_width;
    } item_t;

    typedef struct packed {
        logic        request_dropped;
        logic [3:0]  outcome;
        logic        success;
        logic        done_res;
        logic        busy_res;
        logic [15:0] drive_close_width;
        logic [15:0] drive_open_width;
        logic [7:0]  drive_command;
    } result_t;

endpackage

@@ hdl/gripper_command_sequencer.sv @@
// Gripper command sequencer.
// Input stream (s_*): one transaction is either a new request (tuser = 1) with
// command and target width, or one fieldbus tick (tuser = 0) that carries the
// device feedback. Output stream (m_*): exactly one result per input
// transaction, in order, with the command word and width values to drive and
// the run status (busy, done, success, outcome, dropped request).
// Configuration (cfg_*): one 16-bit register write per transaction, taken at
// any time; write only while no item is in flight.
// The item sits in the input register, then the sequencer step loads the result
// register, from which it can be taken. Throughput is one item per clock while
// the receiver takes results; the sequencer state is updated in a single pass
// per item, so back-to-back ticks and requests are sustained.
// When the receiver stalls, the result register holds its transaction and the
// input register holds one more item; s_tready falls only when both are full.
// Reset returns the sequencer to idle with a neutral command, the drive widths
// to the default open and close targets and the configuration registers to
// their defaults.
module gripper_command_sequencer
    import gcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // fields from bit 0: request_cmd[2:0], request_width[18:3], jaw_state[34:19],
    // jaw_fault[50:35], axis_fault[66:51], finger_width[82:67], zero fill
    input  logic [87:0] s_tdata,
    // fields from bit 0: req_type
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields from bit 0: drive_command[7:0], drive_open_width[23:8],
    // drive_close_width[39:24], busy_res[40], done_res[41], success[42],
    // outcome[46:43], request_dropped[47]
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_vld_reg, in_vld_next;
    result_t res;
    result_t res_reg;
    logic    out_vld_reg, out_vld_next;
    logic    step;

    gcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gcs_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .item   (item_reg),
        .result (res)
    );

    // Advance when an item waits and the result register is free or drains
    assign step     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (step)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the input item and the result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.req_type      <= s_tuser;
            item_reg.request_cmd   <= s_tdata[2:0];
            item_reg.request_width <= s_tdata[18:3];
            item_reg.jaw_state     <= s_tdata[34:19];
            item_reg.jaw_fault     <= s_tdata[50:35];
            item_reg.axis_fault    <= s_tdata[66:51];
            item_reg.finger_width  <= s_tdata[82:67];
        end
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = res_reg;

    // A processed item always shows up as a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_tvalid)
        else $error("processed item produced no result");

    // An item blocked by a full result register stays in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !step) |=> in_vld_reg)
        else $error("input item lost while stalled");

endmodule

@@ hdl/gcs_cfg_regs.sv @@
module gcs_cfg_regs
    import gcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // Registers are always writable
    assign cfg_ready = 1'b1;
    assign cfg     = cfg_reg;

    // Take one register write per transaction; ignore indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ready_timeout      <= RST_READY_TIMEOUT;
            cfg_reg.move_timeout       <= RST_MOVE_TIMEOUT;
            cfg_reg.position_tolerance <= RST_POS_TOL;
            cfg_reg.open_target        <= RST_OPEN_TARGET;
            cfg_reg.close_target       <= RST_CLOSE_TARGET;
            cfg_reg.min_width          <= RST_MIN_WIDTH;
            cfg_reg.max_width          <= RST_MAX_WIDTH;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                REG_READY_TIMEOUT: cfg_reg.ready_timeout      <= cfg_data;
                REG_MOVE_TIMEOUT:  cfg_reg.move_timeout       <= cfg_data;
                REG_POS_TOL:       cfg_reg.position_tolerance <= cfg_data;
                REG_OPEN_TARGET:   cfg_reg.open_target        <= cfg_data;
                REG_CLOSE_TARGET:  cfg_reg.close_target       <= cfg_data;
                REG_MIN_WIDTH:     cfg_reg.min_width          <= cfg_data;
                REG_MAX_WIDTH:     cfg_reg.max_width          <= cfg_data;
                default:           ;
            endcase
        end
    end

endmodule

@@ hdl/gcs_seq.sv @@
module gcs_seq
    import gcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [2:0]  act_reg, act_next;
    logic [15:0] target_reg, target_next;
    logic [15:0] open_w_reg, open_w_next;
    logic [15:0] close_w_reg, close_w_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [3:0]  pend_reg, pend_next;

    // Hold sequencer state; advance only when an item is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            act_reg     <= '0;
            target_reg  <= '0;
            open_w_reg  <= RST_OPEN_TARGET;
            close_w_reg <= RST_CLOSE_TARGET;
            cmd_reg     <= CMD_NEUTRAL;
            pend_reg    <= OC_NONE;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            act_reg     <= act_next;
            target_reg  <= target_next;
            open_w_reg  <= open_w_next;
            close_w_reg <= close_w_next;
            cmd_reg     <= cmd_next;
            pend_reg    <= pend_next;
        end
    end

    // Next state and result for one item
    always_comb
    begin
        logic        fault;
        logic        ready;
        logic [15:0] tick_inc;
        logic [15:0] diff;
        logic [15:0] tgt;
        logic        res_ok;
        logic        done;
        logic        ok;
        logic [3:0]  oc;
        logic        dropped;

        fault = (item.jaw_state == CS_FAULT) || (item.jaw_fault != '0)
                || (item.axis_fault != '0);
        ready = (item.jaw_state == CS_READY_A) || (item.jaw_state == CS_READY_B)
                || (item.jaw_state == CS_READY_C) || (item.jaw_state == CS_READY_D);
        tick_inc = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
        diff = (item.finger_width >= target_reg) ? item.finger_width - target_reg
                                                  : target_reg - item.finger_width;

        // Resolve the motion target for the ready wait
        tgt    = target_reg;
        res_ok = 1'b1;
        case (act_reg)
            RQ_OPEN:  tgt = cfg.open_target;
            RQ_CLOSE: tgt = cfg.close_target;
            RQ_MOVE:  tgt = target_reg;
            default:  res_ok = 1'b0;
        endcase

        phase_next   = phase_reg;
        tick_next    = tick_reg;
        act_next     = act_reg;
        target_next  = target_reg;
        open_w_next  = open_w_reg;
        close_w_next = close_w_reg;
        cmd_next     = cmd_reg;
        pend_next    = pend_reg;
        done         = 1'b0;
        ok           = 1'b0;
        oc           = OC_NONE;
        dropped      = 1'b0;

        if (item.req_type)
        begin
            // New request: drop it while a run is active
            if (phase_reg != PH_IDLE)
            begin
                dropped = 1'b1;
            end
            else
            begin
                act_next    = item.request_cmd;
                target_next = item.request_width;
                tick_next   = '0;
                if (item.request_cmd == RQ_STATUS)
                begin
                    pend_next = OC_NONE;
                    cmd_next  = CMD_NEUTRAL;
                    done      = 1'b1;
                    ok        = 1'b1;
                    oc        = OC_STATUS;
                end
                else
                begin
                    phase_next = PH_CLEAR_PULSE;
                    cmd_next   = CMD_CLEAR;
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE: ;
                PH_CLEAR_PULSE:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= CLEAR_TICKS)
                    begin
                        phase_next = PH_FAULT_WAIT;
                        tick_next  = '0;
                        cmd_next   = CMD_NEUTRAL;
                    end
                end
                PH_FAULT_WAIT:
                begin
                    if (!fault)
                    begin
                        phase_next = PH_READY_WAIT;
                        tick_next  = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= cfg.ready_timeout)
                        begin
                            phase_next = PH_NEUTRALIZE;
                            tick_next  = '0;
                            cmd_next   = CMD_NEUTRAL;
                            pend_next  = OC_CLEAR_FAIL;
                        end
                    end
                end
                PH_READY_WAIT:
                begin
                    if (act_reg == RQ_CLEAR)
                    begin
                        tick_next = tick_inc;
                        if (fault || ready || (tick_inc >= cfg.ready_timeout))
                        begin
                            done = 1'b1;
                            ok   = 1'b1;
                            oc   = OC_CLEARED;
                        end
                    end
                    else if (fault)
                    begin
                        phase_next = PH_NEUTRALIZE;
                        tick_next  = '0;
                        cmd_next   = CMD_NEUTRAL;
                        pend_next  = OC_READY_FAIL;
                    end
                    else if (ready)
                    begin
                        if (!res_ok)
                        begin
                            done = 1'b1;
                            oc   = OC_UNKNOWN;
                        end
                        else if ((act_reg == RQ_MOVE)
                                 && ((tgt < cfg.min_width) || (tgt > cfg.max_width)))
                        begin
                            done = 1'b1;
                            oc   = OC_RANGE;
                        end
                        else
                        begin
                            target_next = tgt;
                            tick_next   = '0;
                            cmd_next    = CMD_NEUTRAL;
                            if (tgt > item.finger_width)
                            begin
                                open_w_next = tgt;
                                phase_next  = PH_PRE_OPEN;
                            end
                            else if (tgt < item.finger_width)
                            begin
                                close_w_next = tgt;
                                phase_next   = PH_PRE_CLOSE;
                            end
                            else
                            begin
                                done = 1'b1;
                                ok   = 1'b1;
                                oc   = OC_ALREADY;
                            end
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= cfg.ready_timeout)
                        begin
                            phase_next = PH_NEUTRALIZE;
                            tick_next  = '0;
                            cmd_next   = CMD_NEUTRAL;
                            pend_next  = OC_READY_FAIL;
                        end
                    end
                end
                PH_PRE_OPEN, PH_PRE_CLOSE:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= NEUTRAL_PULSE_TICKS)
                    begin
                        cmd_next   = (phase_reg == PH_PRE_OPEN) ? CMD_OPEN : CMD_CLOSE;
                        phase_next = PH_MOVE_PULSE;
                        tick_next  = '0;
                    end
                end
                PH_MOVE_PULSE:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= MOVE_PULSE_TICKS)
                    begin
                        cmd_next   = CMD_NEUTRAL;
                        phase_next = PH_MOVE_WAIT;
                        tick_next  = '0;
                    end
                end
                PH_MOVE_WAIT:
                begin
                    if (fault)
                    begin
                        phase_next = PH_NEUTRALIZE;
                        tick_next  = '0;
                        cmd_next   = CMD_NEUTRAL;
                        pend_next  = OC_MOVE_FAIL;
                    end
                    else if ((item.jaw_state == CS_READY_C)
                             || (item.jaw_state == CS_READY_D)
                             || (item.jaw_state == CS_TERM_E))
                    begin
                        done = 1'b1;
                        ok   = 1'b1;
                        oc   = OC_TERMINAL;
                    end
                    else if (diff <= cfg.position_tolerance)
                    begin
                        done = 1'b1;
                        ok   = 1'b1;
                        oc   = OC_REACHED;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= cfg.move_timeout)
                        begin
                            phase_next = PH_NEUTRALIZE;
                            tick_next  = '0;
                            cmd_next   = CMD_NEUTRAL;
                            pend_next  = OC_MOVE_FAIL;
                        end
                    end
                end
                PH_NEUTRALIZE:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= NEUTRALIZE_TICKS)
                    begin
                        done = 1'b1;
                        oc   = pend_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    cmd_next   = CMD_NEUTRAL;
                end
            endcase

            // Finish the run: back to idle with a neutral command
            if (done)
            begin
                phase_next = PH_IDLE;
                tick_next  = '0;
                pend_next  = OC_NONE;
                cmd_next   = CMD_NEUTRAL;
            end
        end

        // Requests show the drive outputs after they are taken, ticks the outputs before
        if (item.req_type)
        begin
            result.drive_command     = cmd_next;
            result.drive_open_width  = open_w_next;
            result.drive_close_width = close_w_next;
        end
        else
        begin
            result.drive_command     = cmd_reg;
            result.drive_open_width  = open_w_reg;
            result.drive_close_width = close_w_reg;
        end
        result.busy_res        = (phase_next != PH_IDLE);
        result.done_res        = done;
        result.success         = ok;
        result.outcome         = oc;
        result.request_dropped = dropped;
    end

    // A finished run leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.done_res) |=> (phase_reg == PH_IDLE))
        else $error("run finished but sequencer not idle");

    // Success and a nonzero outcome only come with a finished run
    assert property (@(posedge clk) disable iff (!rst_n)
        !result.done_res |-> (!result.success && (result.outcome == OC_NONE)))
        else $error("outcome reported without a finished run");

    // A dropped request leaves the active run untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.request_dropped) |=> ($stable(phase_reg) && $stable(tick_reg)))
        else $error("dropped request disturbed the active run");

    // The drive command is neutral whenever the sequencer is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (cmd_reg == CMD_NEUTRAL))
        else $error("non-neutral command while idle");

endmodule
